// File: rtl/cassette_tape_waveform_generator_assert.svh
// Assertion macros for the cassette tape waveform generator.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef CASSETTE_TAPE_WAVEFORM_GENERATOR_ASSERT_SVH
`define CASSETTE_TAPE_WAVEFORM_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define CTWG_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("ctwg assertion failed");
`define CTWG_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("ctwg assertion failed");
`else
`define CTWG_ASSERT(lbl, cond)
`define CTWG_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// File: rtl/ctwg_pkg.sv
// Package for the cassette tape waveform generator: frame layout tables,
// op and register codes, and helper functions. No dependencies.
`default_nettype none
package ctwg_pkg;

  localparam int unsigned HeaderBytes = 128;
  localparam int unsigned FifoDepth   = 256;
  localparam int unsigned HdrAw       = $clog2(HeaderBytes);
  localparam int unsigned FifoAw      = $clog2(FifoDepth);
  localparam logic [4:0]  SegDone     = 5'd16;
  localparam logic [7:0]  LenLoAddr   = 8'h12;
  localparam logic [7:0]  LenHiAddr   = 8'h13;

  localparam logic [1:0] OpTick = 2'd0;
  localparam logic [1:0] OpHead = 2'd1;
  localparam logic [1:0] OpBody = 2'd2;

  localparam logic [2:0] RegLongHigh  = 3'd0;
  localparam logic [2:0] RegLongLow   = 3'd1;
  localparam logic [2:0] RegShortHigh = 3'd2;
  localparam logic [2:0] RegShortLow  = 3'd3;
  localparam logic [2:0] RegGap       = 3'd4;
  localparam logic [2:0] RegHeadTone  = 3'd5;
  localparam logic [2:0] RegBodyTone  = 3'd6;

  typedef enum logic [2:0] {
    KindGap,
    KindZero,
    KindOne,
    KindHead,
    KindBody
  } kind_e;

  function automatic kind_e seg_kind(input logic [3:0] seg);
    kind_e k;
    case (seg)
      4'd0:                             k = KindGap;
      4'd1, 4'd3, 4'd7, 4'd10, 4'd12:   k = KindZero;
      4'd5, 4'd8:                       k = KindHead;
      4'd14:                            k = KindBody;
      default:                          k = KindOne;
    endcase
    return k;
  endfunction

  // Fixed bit counts of tone segments; zero where a register sets the count.
  function automatic logic [15:0] seg_bits(input logic [3:0] seg);
    logic [15:0] n;
    case (seg)
      4'd2, 4'd3:   n = 16'd40;
      4'd7:         n = 16'd256;
      4'd11, 4'd12: n = 16'd20;
      4'd4, 4'd6, 4'd9, 4'd13, 4'd15: n = 16'd1;
      default:      n = 16'd0;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] ones_in(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, b[i]};
    end
    return n;
  endfunction

  function automatic logic [7:0] max1_8(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  function automatic logic [15:0] max1_16(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/cassette_tape_waveform_generator.sv
// Cassette tape waveform generator: one word in, one result word out.
// Result is valid in the cycle after input acceptance; one word per
// cycle sustained, set by the single result register (in_ready_o stays high
// while the result register is empty or being drained).
// Reset: asynchronous, active low; clears control state and sets the
// registers to their defaults. Header and body stores are not cleared.
`default_nettype none
`include "cassette_tape_waveform_generator_assert.svh"
module cassette_tape_waveform_generator
  import ctwg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       sample_o,
  output logic             accepted_o,
  output logic             underrun_o,
  output logic             finished_o,
  output logic [4:0]       frame_phase_o
);

  logic [7:0]  long_high_q, long_low_q, short_high_q, short_low_q;
  logic [15:0] gap_q, head_tone_q, body_tone_q;

  logic [7:0]  hdr_mem [HeaderBytes];
  logic [7:0]  fifo_mem [FifoDepth];
  logic [7:0]  hdr_rd_q, fifo_rd_q;
  logic [7:0]  len_lo_q, len_hi_q;

  logic [HdrAw:0]    fill_q, fill_d;
  logic [FifoAw-1:0] rptr_q, rptr_d, wptr_q, wptr_d;
  logic [FifoAw:0]   level_q, level_d;
  logic [4:0]  seg_q, seg_d;
  logic [15:0] sih_q, sih_d;
  logic [15:0] bis_q, bis_d;
  logic [3:0]  bib_q, bib_d;
  logic [16:0] bir_q, bir_d;
  logic [15:0] cks_q, cks_d;

  logic        out_valid_q;
  logic [7:0]  sample_q, sample_d;
  logic        accepted_q, accepted_d, underrun_q, underrun_d;

  logic        take;
  logic        hdr_we, fifo_we;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_high_q  <= 8'd24;
      long_low_q   <= 8'd29;
      short_high_q <= 8'd11;
      short_low_q  <= 8'd15;
      gap_q        <= 16'd10000;
      head_tone_q  <= 16'd10000;
      body_tone_q  <= 16'd10000;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegLongHigh:  long_high_q  <= cfg_data_i[7:0];
        RegLongLow:   long_low_q   <= cfg_data_i[7:0];
        RegShortHigh: short_high_q <= cfg_data_i[7:0];
        RegShortLow:  short_low_q  <= cfg_data_i[7:0];
        RegGap:       gap_q        <= cfg_data_i;
        RegHeadTone:  head_tone_q  <= cfg_data_i;
        RegBodyTone:  body_tone_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Stores are read continuously at the current position. The start bit of
  // each byte lasts at least two ticks, so the registered read data is
  // settled before any data bit needs it.
  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_mem[fill_q[HdrAw-1:0]] <= data_byte_i;
    end
    hdr_rd_q <= hdr_mem[bir_q[HdrAw-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_mem[wptr_q] <= data_byte_i;
    end
    fifo_rd_q <= fifo_mem[rptr_q];
  end

  // Body length bytes are kept in flops as they are pushed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_lo_q <= 8'd0;
      len_hi_q <= 8'd0;
    end else if (hdr_we) begin
      if (fill_q == {1'b0, LenLoAddr[HdrAw-1:0]}) len_lo_q <= data_byte_i;
      if (fill_q == {1'b0, LenHiAddr[HdrAw-1:0]}) len_hi_q <= data_byte_i;
    end
  end

  kind_e       kind;
  logic        is_rec, is_data, bit_v, hl_hit, half_end;
  logic [16:0] len, n_rec;
  logic [15:0] n_tone, sih_inc;
  logic [7:0]  data, hl, ll;
  logic [8:0]  bit_len;
  logic [2:0]  bit_idx;
  logic        adv_seg;

  always_comb begin
    kind    = seg_kind(seg_q[3:0]);
    is_rec  = (kind == KindHead) || (kind == KindBody);
    len     = (kind == KindBody) ? {1'b0, len_hi_q, len_lo_q} : 17'(HeaderBytes);
    is_data = bir_q < len;
    n_rec   = len + 17'd2;
    if (is_data) begin
      data = (kind == KindBody) ? fifo_rd_q : hdr_rd_q;
    end else if (bir_q == len) begin
      data = cks_q[15:8];
    end else begin
      data = cks_q[7:0];
    end
    bit_idx = 3'(4'd8 - bib_q);
    if (is_rec) begin
      bit_v = (bib_q == 4'd0) ? 1'b1 : data[bit_idx];
    end else begin
      bit_v = (kind == KindOne);
    end
    n_tone = seg_bits(seg_q[3:0]);
    if (seg_q == 5'd1)  n_tone = head_tone_q;
    if (seg_q == 5'd10) n_tone = body_tone_q;
    n_tone  = max1_16(n_tone);
    hl      = max1_8(bit_v ? long_high_q : short_high_q);
    ll      = max1_8(bit_v ? long_low_q : short_low_q);
    bit_len = {1'b0, hl} + {1'b0, ll};
    hl_hit  = sih_q < {8'd0, hl};
    sih_inc = sih_q + 16'd1;
    half_end = {1'b0, sih_inc} >= {8'd0, bit_len};
  end

  always_comb begin
    fill_d     = fill_q;
    rptr_d     = rptr_q;
    wptr_d     = wptr_q;
    level_d    = level_q;
    seg_d      = seg_q;
    sih_d      = sih_q;
    bis_d      = bis_q;
    bib_d      = bib_q;
    bir_d      = bir_q;
    cks_d      = cks_q;
    sample_d   = 8'd0;
    accepted_d = 1'b0;
    underrun_d = 1'b0;
    hdr_we     = 1'b0;
    fifo_we    = 1'b0;
    adv_seg    = 1'b0;
    if (take) begin
      case (op_i)
        OpTick: begin
          if (seg_q < SegDone) begin
            if (kind == KindGap) begin
              sih_d = sih_inc;
              if (sih_inc >= max1_16(gap_q)) adv_seg = 1'b1;
            end else if (is_rec && is_data && (bib_q == 4'd0) &&
                         ((kind == KindHead) ? (bir_q >= {9'd0, fill_q})
                                             : (level_q == '0))) begin
              underrun_d = 1'b1;
            end else begin
              sample_d = hl_hit ? 8'hFF : 8'h00;
              sih_d    = sih_inc;
              if (half_end) begin
                sih_d = 16'd0;
                if (is_rec) begin
                  bib_d = bib_q + 4'd1;
                  if (bib_q == 4'd8) begin
                    bib_d = 4'd0;
                    if (is_data) begin
                      cks_d = cks_q + {12'd0, ones_in(data)};
                      if (kind == KindBody) begin
                        rptr_d  = rptr_q + 1'b1;
                        level_d = level_q - 1'b1;
                      end
                    end
                    bir_d = bir_q + 17'd1;
                    if (bir_d >= n_rec) adv_seg = 1'b1;
                  end
                end else begin
                  bis_d = bis_q + 16'd1;
                  if (bis_d >= n_tone) adv_seg = 1'b1;
                end
              end
            end
          end
        end
        OpHead: begin
          if (fill_q < (HdrAw + 1)'(HeaderBytes)) begin
            hdr_we     = 1'b1;
            fill_d     = fill_q + 1'b1;
            accepted_d = 1'b1;
          end
        end
        OpBody: begin
          if ((level_q < (FifoAw + 1)'(FifoDepth)) && (seg_q < SegDone)) begin
            fifo_we    = 1'b1;
            wptr_d     = wptr_q + 1'b1;
            level_d    = level_q + 1'b1;
            accepted_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    if (adv_seg) begin
      seg_d = seg_q + 5'd1;
      sih_d = 16'd0;
      bis_d = 16'd0;
      bib_d = 4'd0;
      bir_d = 17'd0;
      cks_d = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      rptr_q      <= '0;
      wptr_q      <= '0;
      level_q     <= '0;
      seg_q       <= 5'd0;
      sih_q       <= 16'd0;
      bis_q       <= 16'd0;
      bib_q       <= 4'd0;
      bir_q       <= 17'd0;
      cks_q       <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      rptr_q  <= rptr_d;
      wptr_q  <= wptr_d;
      level_q <= level_d;
      seg_q   <= seg_d;
      sih_q   <= sih_d;
      bis_q   <= bis_d;
      bib_q   <= bib_d;
      bir_q   <= bir_d;
      cks_q   <= cks_d;
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      sample_q   <= sample_d;
      accepted_q <= accepted_d;
      underrun_q <= underrun_d;
    end
  end

  // Phase and finished follow the state after the word was processed; state
  // only moves on accepted words, so the live registers match that word.
  assign out_valid_o   = out_valid_q;
  assign sample_o      = sample_q;
  assign accepted_o    = accepted_q;
  assign underrun_o    = underrun_q;
  assign finished_o    = seg_q >= SegDone;
  assign frame_phase_o = seg_q;

  `CTWG_ASSERT(a_level_ptrs, level_q[FifoAw-1:0] == FifoAw'(wptr_q - rptr_q))
  `CTWG_ASSERT(a_fill_max, fill_q <= (HdrAw + 1)'(HeaderBytes))
  `CTWG_ASSERT(a_seg_max, seg_q <= SegDone)
  `CTWG_ASSERT_NEXT(a_underrun_holds, take && underrun_d, $stable(seg_q) && $stable(sih_q))

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the cassette tape waveform generator.
// Needs only ctwg_pkg and the block: a frame predictor tracks every word and
// each result word is compared field by field against it.
`timescale 1ns / 100ps

module tb_top;
  import ctwg_pkg::*;

  typedef struct packed {
    logic [7:0] sample;
    logic       accepted;
    logic       underrun;
    logic       finished;
    logic [4:0] phase;
  } tape_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = OpTick;
  logic [7:0]  data_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  sample;
  logic        accepted;
  logic        underrun;
  logic        finished;
  logic [4:0]  frame_phase;

  cassette_tape_waveform_generator u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .op_i         (op),
    .data_byte_i  (data_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .sample_o     (sample),
    .accepted_o   (accepted),
    .underrun_o   (underrun),
    .finished_o   (finished),
    .frame_phase_o(frame_phase)
  );

  localparam logic [1:0] OpNone = 2'd3;

  // Predictor state: registers, stores and frame position.
  logic [7:0]  lh_len, ll_len, sh_len, sl_len;
  logic [15:0] gap_len, head_tone, body_tone;
  logic [7:0]  hdr_mem [HeaderBytes];
  logic [7:0]  body_mem [FifoDepth];
  int          hdr_fill, rd_ptr, wr_ptr, body_lvl;
  int          seg, pos_in_half, bits_done, bit_idx, byte_idx;
  logic [15:0] ones_sum;

  logic [7:0]  hdr_plan [HeaderBytes];
  tape_word_t  pending_words [$];
  int          err_cnt = 0;
  int          word_cnt = 0;
  int          underrun_cnt = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12ns * 3_000_000);
    $display("Timeout waiting for the block");
    $display("Some tests failed");
    $finish;
  end

  function automatic kind_e zone_of(input int s);
    case (s)
      0:                  return KindGap;
      1, 3, 7, 10, 12:    return KindZero;
      5, 8:               return KindHead;
      14:                 return KindBody;
      default:            return KindOne;
    endcase
  endfunction

  function automatic int nz(input int v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic int popcount8(input logic [7:0] b);
    int n;
    n = 0;
    for (int i = 0; i < 8; i++) n += b[i];
    return n;
  endfunction

  function automatic void enter_next_zone();
    seg++;
    pos_in_half = 0;
    bits_done = 0;
    bit_idx = 0;
    byte_idx = 0;
    ones_sum = 16'd0;
  endfunction

  // One tape sample; bit 8 set means the needed byte was missing.
  function automatic logic [8:0] tape_tick();
    kind_e      k;
    int         len, hl, ll, n;
    logic       bit_v, is_data;
    logic [7:0] d, s;
    k = zone_of(seg);
    is_data = 1'b0;
    d = 8'd0;
    if (k == KindGap) begin
      pos_in_half++;
      if (pos_in_half >= nz(gap_len)) enter_next_zone();
      return 9'd0;
    end
    if (k == KindHead || k == KindBody) begin
      len = (k == KindHead) ? HeaderBytes : {hdr_mem[8'h13], hdr_mem[8'h12]};
      if (byte_idx < len) begin
        is_data = 1'b1;
        if (k == KindHead) begin
          if (byte_idx >= hdr_fill) return 9'h100;
          d = hdr_mem[byte_idx];
        end else begin
          if (body_lvl == 0) return 9'h100;
          d = body_mem[rd_ptr];
        end
      end else if (byte_idx == len) begin
        d = ones_sum[15:8];
      end else begin
        d = ones_sum[7:0];
      end
      bit_v = (bit_idx == 0) ? 1'b1 : d[8 - bit_idx];
      n = len + 2;
    end else begin
      bit_v = (k == KindOne);
      case (seg)
        1:         n = head_tone;
        10:        n = body_tone;
        2, 3:      n = 40;
        7:         n = 256;
        11, 12:    n = 20;
        default:   n = 1;
      endcase
      n = nz(n);
    end
    hl = nz(bit_v ? lh_len : sh_len);
    ll = nz(bit_v ? ll_len : sl_len);
    s = (pos_in_half < hl) ? 8'hFF : 8'h00;
    pos_in_half++;
    if (pos_in_half >= hl + ll) begin
      pos_in_half = 0;
      if (k == KindHead || k == KindBody) begin
        bit_idx++;
        if (bit_idx >= 9) begin
          bit_idx = 0;
          if (is_data) begin
            ones_sum = ones_sum + 16'(popcount8(d));
            if (k == KindBody) begin
              rd_ptr = (rd_ptr + 1) % FifoDepth;
              body_lvl--;
            end
          end
          byte_idx++;
          if (byte_idx >= n) enter_next_zone();
        end
      end else begin
        bits_done++;
        if (bits_done >= n) enter_next_zone();
      end
    end
    return {1'b0, s};
  endfunction

  function automatic tape_word_t predict_word(input logic [1:0] o, input logic [7:0] b);
    tape_word_t w;
    logic [8:0] r;
    w = '0;
    if (o == OpTick) begin
      if (seg < SegDone) begin
        r = tape_tick();
        if (r[8]) w.underrun = 1'b1;
        else w.sample = r[7:0];
      end
    end else if (o == OpHead) begin
      if (hdr_fill < HeaderBytes) begin
        hdr_mem[hdr_fill] = b;
        hdr_fill++;
        w.accepted = 1'b1;
      end
    end else if (o == OpBody) begin
      if (body_lvl < FifoDepth && seg < SegDone) begin
        body_mem[wr_ptr] = b;
        wr_ptr = (wr_ptr + 1) % FifoDepth;
        body_lvl++;
        w.accepted = 1'b1;
      end
    end
    w.finished = (seg >= SegDone);
    w.phase = 5'(seg);
    return w;
  endfunction

  // Sends one word; valid stays high afterwards until idled or drained.
  task automatic send_word(input logic [1:0] o, input logic [7:0] b);
    if (idle_on && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    op <= o;
    data_byte <= b;
    do @(posedge clk_i); while (!in_ready);
    pending_words.push_back(predict_word(o, b));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [15:0] v [7]);
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= v[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    lh_len = v[RegLongHigh][7:0];
    ll_len = v[RegLongLow][7:0];
    sh_len = v[RegShortHigh][7:0];
    sl_len = v[RegShortLow][7:0];
    gap_len = v[RegGap];
    head_tone = v[RegHeadTone];
    body_tone = v[RegBodyTone];
  endtask

  // Random word with a bias toward ticks and in-order header bytes.
  task automatic send_random(input int head_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < head_pct)
      send_word(OpHead, (hdr_fill < HeaderBytes) ? hdr_plan[hdr_fill] : 8'($urandom));
    else if (r < head_pct + 6)
      send_word(OpBody, 8'($urandom));
    else if (r < head_pct + 9)
      send_word(OpNone, 8'($urandom));
    else
      send_word(OpTick, 8'($urandom));
  endtask

  // Checks each result word against the oldest prediction.
  always @(posedge clk_i) begin
    tape_word_t got, want;
    if (rst_ni && out_valid && out_ready) begin
      got = '{sample, accepted, underrun, finished, frame_phase};
      word_cnt++;
      if (got.underrun) underrun_cnt++;
      if (pending_words.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("Unexpected result word %p", got);
      end else begin
        want = pending_words.pop_front();
        if (got !== want) begin
          err_cnt++;
          if (err_cnt <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_directed_corners();
    logic [15:0] regs [7];
    send_word(OpTick, 8'h00);
    send_word(OpNone, 8'hFF);
    send_word(OpBody, 8'h00);
    send_word(OpBody, 8'hFF);
    send_word(OpHead, hdr_plan[0]);
    send_word(OpHead, hdr_plan[1]);
    send_word(OpTick, 8'hFF);
    drain();
    // Zero registers behave as one, so the tones run at two samples per bit.
    regs = '{default: 16'd0};
    write_regs(regs);
    repeat (14) send_word(OpTick, 8'h00);
    send_word(OpHead, hdr_plan[2]);
    send_word(OpTick, 8'h00);
    drain();
  endtask

  task automatic test_random_stream();
    logic [15:0] regs [7];
    for (int i = 0; i < 4; i++) regs[i] = 16'($urandom_range(0, 4));
    regs[RegGap] = 16'($urandom_range(1, 40));
    regs[RegHeadTone] = 16'($urandom_range(1, 30));
    regs[RegBodyTone] = 16'($urandom_range(1, 30));
    write_regs(regs);
    for (int i = 0; i < 800; i++) begin
      if (i == 300) hold_req = 1'b1;
      send_random(6);
    end
    drain();
  endtask

  task automatic test_long_pulses();
    logic [15:0] regs [7];
    regs = '{16'd255, 16'd255, 16'd255, 16'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    write_regs(regs);
    repeat (200) send_random(3);
    drain();
  endtask

  task automatic test_full_frame();
    logic [15:0] regs [7];
    int guard;
    regs = '{16'd1, 16'd2, 16'd1, 16'd1, 16'd3, 16'd2, 16'd2};
    write_regs(regs);
    guard = 0;
    while (seg < SegDone && guard < 250) begin
      if (guard == 100) idle_on = 1'b0;
      send_random(12);
      guard++;
    end
    idle_on = 1'b0;
    repeat (150) send_random(5);
  endtask

  initial begin
    int body_len;
    lh_len = 8'd24; ll_len = 8'd29; sh_len = 8'd11; sl_len = 8'd15;
    gap_len = 16'd10000; head_tone = 16'd10000; body_tone = 16'd10000;
    hdr_fill = 0; rd_ptr = 0; wr_ptr = 0; body_lvl = 0;
    seg = 0; pos_in_half = 0; bits_done = 0; bit_idx = 0; byte_idx = 0;
    ones_sum = 16'd0;
    body_len = $urandom_range(0, 6);
    foreach (hdr_plan[i]) hdr_plan[i] = 8'($urandom);
    hdr_plan[0] = 8'hFF;
    hdr_plan[1] = 8'h00;
    hdr_plan[8'h12] = 8'(body_len);
    hdr_plan[8'h13] = 8'h00;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_random_stream();
    test_long_pulses();
    test_full_frame();
    drain();
    repeat (10) @(posedge clk_i);

    $display("Checked %0d result words (%0d underruns), body of %0d bytes, final phase %0d.",
             word_cnt, underrun_cnt, body_len, seg);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ctwg_pkg.sv
rtl/cassette_tape_waveform_generator.sv
tb/tb_top.sv
